/* design/fdcm_pkg.sv */
// shared types and constants for the frequency and duty cycle meter
package fdcm_pkg;

  localparam int RATE_WIDTH = 27;
  localparam logic [RATE_WIDTH-1:0] RATE_RESET = 27'd12000000;

  localparam int OUT_WIDTH  = 32;
  localparam int FREQ_WIDTH = 33;
  localparam int DUTY_WIDTH = 14;

  // scale factors for centihertz and basis points
  localparam int FREQ_SCALE_WIDTH = 7;
  localparam logic [FREQ_SCALE_WIDTH-1:0] FREQ_SCALE = 7'd100;
  localparam int DUTY_SCALE_WIDTH = 14;
  localparam logic [DUTY_SCALE_WIDTH-1:0] DUTY_SCALE = 14'd10000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef enum logic [1:0] {
    PH_RISE1 = 2'd0,
    PH_FALL  = 2'd1,
    PH_RISE2 = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_FREQ = 2'd1,
    BK_DUTY = 2'd2,
    BK_DONE = 2'd3
  } back_state_t;

endpackage

/* design/fdcm_in_if.sv */
// sample channel: one timer tick with the sampled signal level
interface fdcm_in_if;
  logic valid;
  logic ready;
  logic signal_level;

  modport source (output valid, output signal_level, input ready);
  modport sink (input valid, input signal_level, output ready);
endinterface

/* design/fdcm_out_if.sv */
// result channel: period, high time, frequency and duty of one measurement
interface fdcm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] period_ticks;
  logic [31:0] high_ticks;
  logic [32:0] frequency_centihz;
  logic [13:0] duty_basis_points;

  modport source (output valid, output period_ticks, output high_ticks,
                  output frequency_centihz, output duty_basis_points, input ready);
  modport sink (input valid, input period_ticks, input high_ticks,
                input frequency_centihz, input duty_basis_points, output ready);
endinterface

/* design/frequency_duty_cycle_meter.sv */
// frequency and duty cycle meter: one tick per cycle, two divisions per measurement
// samples are taken every cycle while valid and the measurement queue (4 entries) has room
// each measurement runs a frequency division and then a duty division in the shared divider
// result is registered once both divisions are done and the result register is free
// reset: waits for a first rising edge, level assumed high, tick rate 12000000 hz
module frequency_duty_cycle_meter #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fdcm_pkg::RATE_WIDTH-1:0]   cfg_wdata,
  fdcm_in_if.sink                           samples,
  fdcm_out_if.source                        results
);
  import fdcm_pkg::*;

  logic [RATE_WIDTH-1:0]    tick_rate;
  logic                     accept;
  logic                     push;
  logic [2*COUNT_WIDTH-1:0] push_data;
  logic                     pop;
  logic                     q_full;
  logic                     q_not_empty;
  logic [2*COUNT_WIDTH-1:0] q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= RATE_RESET;
    end else if (cfg_we) begin
      tick_rate <= cfg_wdata;
    end
  end

  assign samples.ready = ~q_full;
  assign accept        = samples.valid & ~q_full;

  fdcm_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .signal_level (samples.signal_level),
    .push         (push),
    .push_data    (push_data)
  );

  fdcm_queue #(.COUNT_WIDTH(COUNT_WIDTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head_data  (q_data)
  );

  fdcm_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .tick_rate   (tick_rate),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .pop         (pop),
    .results     (results)
  );

endmodule

/* design/fdcm_front.sv */
// edge detection, measurement phases and the saturating tick counter
module fdcm_front #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       signal_level,
  output logic                       push,
  output logic [2*COUNT_WIDTH-1:0]   push_data
);
  import fdcm_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  phase_t                   phase;
  phase_t                   phase_next;
  logic                     prev_level;
  logic [COUNT_WIDTH-1:0]   elapsed;
  logic [COUNT_WIDTH-1:0]   elapsed_next;
  logic [COUNT_WIDTH-1:0]   captured_high;
  logic [COUNT_WIDTH-1:0]   captured_high_next;
  logic [COUNT_WIDTH-1:0]   elapsed_inc;
  logic                     rise;
  logic                     fall;
  logic                     closing;

  assign rise        = signal_level & ~prev_level;
  assign fall        = ~signal_level & prev_level;
  assign elapsed_inc = (elapsed == COUNT_MAX) ? COUNT_MAX : elapsed + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_RISE1;
      prev_level    <= 1'b1;
      elapsed       <= '0;
      captured_high <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      prev_level    <= signal_level;
      elapsed       <= elapsed_next;
      captured_high <= captured_high_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    elapsed_next       = elapsed;
    captured_high_next = captured_high;
    closing            = 1'b0;
    case (phase)
      PH_FALL: begin
        elapsed_next = elapsed_inc;
        if (fall) begin
          captured_high_next = elapsed_inc;
          phase_next         = PH_RISE2;
        end
      end
      PH_RISE2: begin
        elapsed_next = elapsed_inc;
        if (rise) begin
          phase_next = PH_RISE1;
          closing    = 1'b1;
        end
      end
      default: begin
        phase_next = PH_RISE1;
        if (rise) begin
          elapsed_next       = '0;
          captured_high_next = '0;
          phase_next         = PH_FALL;
        end
      end
    endcase
  end

  // a saturated period is dropped
  assign push      = accept & closing & (elapsed_inc != COUNT_MAX);
  assign push_data = {elapsed_inc, captured_high};

endmodule

/* design/fdcm_queue.sv */
// short queue of captured measurements between front and back
module fdcm_queue #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [2*COUNT_WIDTH-1:0]   push_data,
  input  logic                       pop,
  output logic                       full,
  output logic                       not_empty,
  output logic [2*COUNT_WIDTH-1:0]   head_data
);
  import fdcm_pkg::*;

  logic [2*COUNT_WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]      wr_ptr;
  logic [QUEUE_AW-1:0]      rd_ptr;
  logic [QUEUE_AW:0]        count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/fdcm_back.sv */
// shared bit-serial divider for frequency and duty, and the result register
module fdcm_back #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [fdcm_pkg::RATE_WIDTH-1:0]     tick_rate,
  input  logic                                q_not_empty,
  input  logic [2*COUNT_WIDTH-1:0]            q_data,
  output logic                                pop,
  fdcm_out_if.source                          results
);
  import fdcm_pkg::*;

  localparam int FREQ_NUM_W = RATE_WIDTH + FREQ_SCALE_WIDTH;
  localparam int DUTY_NUM_W = COUNT_WIDTH + DUTY_SCALE_WIDTH;
  localparam int DVW        = (DUTY_NUM_W > FREQ_NUM_W) ? DUTY_NUM_W : FREQ_NUM_W;
  localparam int STEP_W     = $clog2(DVW + 1);

  back_state_t              state;
  back_state_t              state_next;
  logic                     load_freq;
  logic                     iterate;
  logic                     last_step;
  logic                     load_out;

  logic [STEP_W-1:0]        step;
  logic [COUNT_WIDTH-1:0]   rem;
  logic [DVW-1:0]           dq;
  logic [COUNT_WIDTH-1:0]   divisor;
  logic [COUNT_WIDTH-1:0]   high_hold;
  logic [FREQ_WIDTH-1:0]    freq_q;

  logic [COUNT_WIDTH:0]     rem_sh;
  logic [COUNT_WIDTH:0]     diff;
  logic                     ge;
  logic [COUNT_WIDTH-1:0]   rem_step;
  logic [DVW-1:0]           dq_step;
  logic [FREQ_NUM_W-1:0]    freq_num;
  logic [DUTY_NUM_W-1:0]    duty_num;

  logic                     out_valid;
  logic [OUT_WIDTH-1:0]     out_period;
  logic [OUT_WIDTH-1:0]     out_high;
  logic [FREQ_WIDTH-1:0]    out_freq;
  logic [DUTY_WIDTH-1:0]    out_duty;

  // one quotient bit per cycle, restoring
  assign rem_sh   = {rem, dq[DVW-1]};
  assign diff     = rem_sh - {1'b0, divisor};
  assign ge       = (rem_sh >= {1'b0, divisor});
  assign rem_step = ge ? diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
  assign dq_step  = {dq[DVW-2:0], ge};

  assign freq_num  = tick_rate * FREQ_SCALE;
  assign duty_num  = high_hold * DUTY_SCALE;
  assign last_step = (step == STEP_W'(DVW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_freq  = 1'b0;
    iterate    = 1'b0;
    load_out   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_not_empty) begin
          pop        = 1'b1;
          load_freq  = 1'b1;
          state_next = BK_FREQ;
        end
      end
      BK_FREQ: begin
        iterate = 1'b1;
        if (last_step) begin
          state_next = BK_DUTY;
        end
      end
      BK_DUTY: begin
        iterate = 1'b1;
        if (last_step) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid || results.ready) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_freq) begin
      {divisor, high_hold} <= q_data;
      dq   <= DVW'(freq_num);
      rem  <= '0;
      step <= '0;
    end else if (iterate) begin
      if (last_step && state == BK_FREQ) begin
        // frequency done, start duty on the same divisor
        freq_q <= dq_step[FREQ_WIDTH-1:0];
        dq     <= DVW'(duty_num);
        rem    <= '0;
        step   <= '0;
      end else begin
        dq   <= dq_step;
        rem  <= rem_step;
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_period <= OUT_WIDTH'(divisor);
      out_high   <= OUT_WIDTH'(high_hold);
      out_freq   <= freq_q;
      out_duty   <= dq[DUTY_WIDTH-1:0];
    end
  end

  assign results.valid             = out_valid;
  assign results.period_ticks      = out_period;
  assign results.high_ticks        = out_high;
  assign results.frequency_centihz = out_freq;
  assign results.duty_basis_points = out_duty;

endmodule
